/* design/hcf_pkg.sv */
// ----------------------------------------------------------------------------
// hcf_pkg: shared definitions for the HSL color fader
// Constants, register indexes and sequencer states used by the fader
// and its port checker.
// ----------------------------------------------------------------------------
package hcf_pkg;

   // Pixel chain
   localparam int PIXEL_COUNT = 6;
   localparam int PIX_W       = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
   localparam logic [7:0] PIXEL_HALF = 8'(PIXEL_COUNT / 2);

   // Serial multiplier: 10-bit signed operand times 8-bit unsigned operand,
   // radix-4, one 2-bit digit per cycle, low 16 product bits kept
   localparam int OPA_W   = 10;
   localparam int OPB_W   = 8;
   localparam int PROD_W  = 16;
   localparam int DIGITS  = OPB_W / 2;
   localparam int CNT_W   = $clog2(DIGITS);

   // Register reset values
   localparam logic [7:0] FIRST_HUE_RST   = 8'd0;
   localparam logic [7:0] FIRST_SAT_RST   = 8'd255;
   localparam logic [7:0] FIRST_LIG_RST   = 8'd127;
   localparam logic [7:0] SECOND_RST      = 8'd0;
   localparam logic [7:0] HUE_STEP_RST    = 8'd0;

   // Fade position wraps when it reaches this value
   localparam logic [7:0] FADE_END = 8'd255;

   typedef enum logic [2:0] {
      REG_FIRST_HUE         = 3'd0,
      REG_FIRST_SATURATION  = 3'd1,
      REG_FIRST_LIGHTNESS   = 3'd2,
      REG_SECOND_HUE        = 3'd3,
      REG_SECOND_SATURATION = 3'd4,
      REG_SECOND_LIGHTNESS  = 3'd5,
      REG_PIXEL_HUE_STEP    = 3'd6
   } csr_index_type;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_MUL_H = 8'b0000_0010,
      S_MUL_S = 8'b0000_0100,
      S_MUL_L = 8'b0000_1000,
      S_MUL_K = 8'b0001_0000,
      S_MUL_C = 8'b0010_0000,
      S_MUL_X = 8'b0100_0000,
      S_EMIT  = 8'b1000_0000
   } state_type;

endpackage

/* design/hsl_color_fader_pixels.sv */
// ----------------------------------------------------------------------------
// hsl_color_fader_pixels: HSL color fader for a short RGB pixel chain
// Each render transfer advances the fade (or the hue drift) and produces one
// RGB transfer per pixel, computed by a fixed-point HSL to RGB conversion.
// ----------------------------------------------------------------------------
// Each accepted request with render = 1 produces hcf_pkg::PIXEL_COUNT response
// transfers in pixel order; render = 0 is taken without leaving idle and
// produces nothing. All products run through one shared radix-4 serial
// multiplier that retires one 2-bit digit per cycle. Each pixel needs two
// products (chroma, then mix term) plus an emit step that loads the output
// register. Single mode (all second-color registers zero) goes straight to
// the pixels; dual mode first adds four products for the hue, saturation and
// lightness blend and the hue spread offset. Downstream stall on the response
// channel holds the sequencer in its emit step, since only one finished pixel
// is buffered. The request side stalls from acceptance until the last pixel
// is loaded into the output register, so the next request may be taken while
// that last pixel still waits. Configuration writes are taken any time and
// belong only in idle periods.
// ----------------------------------------------------------------------------
module hsl_color_fader_pixels (
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_write_enable,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_write_data,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_render,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_pixel_index,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output logic       rsp_fade_phase,
   output logic       rsp_last
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [7:0] first_hue_ff, first_hue_in;
   logic [7:0] first_sat_ff, first_sat_in;
   logic [7:0] first_lig_ff, first_lig_in;
   logic [7:0] second_hue_ff, second_hue_in;
   logic [7:0] second_sat_ff, second_sat_in;
   logic [7:0] second_lig_ff, second_lig_in;
   logic [7:0] hue_step_ff, hue_step_in;

   always_comb begin
      first_hue_in  = first_hue_ff;
      first_sat_in  = first_sat_ff;
      first_lig_in  = first_lig_ff;
      second_hue_in = second_hue_ff;
      second_sat_in = second_sat_ff;
      second_lig_in = second_lig_ff;
      hue_step_in   = hue_step_ff;
      if (csr_write_enable) begin
         // an index past the register list is dropped
         unique case (csr_index)
            hcf_pkg::REG_FIRST_HUE:         first_hue_in  = csr_write_data;
            hcf_pkg::REG_FIRST_SATURATION:  first_sat_in  = csr_write_data;
            hcf_pkg::REG_FIRST_LIGHTNESS:   first_lig_in  = csr_write_data;
            hcf_pkg::REG_SECOND_HUE:        second_hue_in = csr_write_data;
            hcf_pkg::REG_SECOND_SATURATION: second_sat_in = csr_write_data;
            hcf_pkg::REG_SECOND_LIGHTNESS:  second_lig_in = csr_write_data;
            hcf_pkg::REG_PIXEL_HUE_STEP:    hue_step_in   = csr_write_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer and datapath registers
   // ---------------------------------------------------------------------
   hcf_pkg::state_type state_ff, state_in;
   logic [hcf_pkg::CNT_W-1:0]  cnt_ff, cnt_in;       // digit counter
   logic [hcf_pkg::PROD_W-1:0] acc_ff, acc_in;       // product accumulator
   logic [hcf_pkg::PIX_W-1:0]  idx_ff, idx_in;       // pixel counter

   // fader state
   logic [7:0] blend_pos_ff, blend_pos_in;
   logic       fade_dir_ff, fade_dir_in;
   logic [7:0] drift_ff, drift_in;

   // per-interval color and per-pixel working values
   logic [7:0] hue_ff, hue_in;     // blended base hue
   logic [7:0] sat_ff, sat_in;
   logic [7:0] lig_ff, lig_in;
   logic [7:0] hcur_ff, hcur_in;   // hue of the current pixel
   logic [7:0] c_ff, c_in;         // chroma
   logic [7:0] x_ff, x_in;         // mix term

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] out_idx_ff, out_idx_in;
   logic [7:0] out_red_ff, out_red_in;
   logic [7:0] out_green_ff, out_green_in;
   logic [7:0] out_blue_ff, out_blue_in;
   logic       out_phase_ff, out_phase_in;
   logic       out_last_ff, out_last_in;

   // ---------------------------------------------------------------------
   // Dual mode blend operands: current color fades toward the target
   // ---------------------------------------------------------------------
   logic       single_mode;
   logic [7:0] cur_h, cur_s, cur_l, tgt_h, tgt_s, tgt_l;
   logic [9:0] wrap_raw;
   logic [7:0] wrap_mod;
   logic signed [hcf_pkg::OPA_W-1:0] dh, ds, dl, step_ext;

   assign single_mode = (second_hue_ff == 8'd0) && (second_sat_ff == 8'd0) &&
                        (second_lig_ff == 8'd0);

   always_comb begin
      if (fade_dir_ff) begin
         cur_h = first_hue_ff;  cur_s = first_sat_ff;  cur_l = first_lig_ff;
         tgt_h = second_hue_ff; tgt_s = second_sat_ff; tgt_l = second_lig_ff;
      end else begin
         cur_h = second_hue_ff; cur_s = second_sat_ff; cur_l = second_lig_ff;
         tgt_h = first_hue_ff;  tgt_s = first_sat_ff;  tgt_l = first_lig_ff;
      end
   end

   // shortest way around the wheel: (384 + tgt - cur) mod 255, minus 127;
   // the raw sum stays below three wheel lengths
   assign wrap_raw = 10'd384 + {2'b00, tgt_h} - {2'b00, cur_h};

   always_comb begin
      if (wrap_raw >= 10'd510) begin
         wrap_mod = 8'(wrap_raw - 10'd510);
      end else if (wrap_raw >= 10'd255) begin
         wrap_mod = 8'(wrap_raw - 10'd255);
      end else begin
         wrap_mod = wrap_raw[7:0];
      end
   end

   assign dh       = signed'({2'b00, wrap_mod} - 10'd127);
   assign ds       = signed'({2'b00, tgt_s} - {2'b00, cur_s});
   assign dl       = signed'({2'b00, tgt_l} - {2'b00, cur_l});
   assign step_ext = signed'({{2{hue_step_ff[7]}}, hue_step_ff});

   // ---------------------------------------------------------------------
   // HSL to RGB operands for the current pixel
   // ---------------------------------------------------------------------
   logic [10:0] hh;         // hue times six
   logic [2:0]  sextant;
   logic [8:0]  h1;
   logic [9:0]  two_l1;
   logic [9:0]  c_opa;
   logic [9:0]  x_opa;
   logic [7:0]  m_val;

   assign hh      = {1'b0, hcur_ff, 2'b00} + {2'b00, hcur_ff, 1'b0};
   assign sextant = hh[10:8];
   assign h1      = {1'b0, hh[7:0]} + 9'd1;
   assign two_l1  = {1'b0, lig_ff, 1'b0} + 10'd2;
   assign c_opa   = lig_ff[7] ? (10'd512 - two_l1) : two_l1;
   assign x_opa   = hh[8] ? (10'd256 - {1'b0, h1}) : {1'b0, h1};
   assign m_val   = lig_ff - {1'b0, c_ff[7:1]};

   // ---------------------------------------------------------------------
   // Shared serial multiplier, most significant digit first
   // ---------------------------------------------------------------------
   logic signed [hcf_pkg::OPA_W-1:0] opa;
   logic [hcf_pkg::OPB_W-1:0]        opb;
   logic [hcf_pkg::PROD_W-1:0]       opa_ext;
   logic [hcf_pkg::PROD_W-1:0]       partial;
   logic [hcf_pkg::PROD_W-1:0]       mul_sum;
   logic [1:0]                       digit;
   logic [7:0]                       mul_hi;
   logic                             last_digit;

   always_comb begin
      unique case (state_ff)
         hcf_pkg::S_MUL_H: begin opa = dh;              opb = blend_pos_ff;        end
         hcf_pkg::S_MUL_S: begin opa = ds;              opb = blend_pos_ff;        end
         hcf_pkg::S_MUL_L: begin opa = dl;              opb = blend_pos_ff;        end
         hcf_pkg::S_MUL_K: begin opa = step_ext;        opb = hcf_pkg::PIXEL_HALF; end
         hcf_pkg::S_MUL_C: begin opa = signed'(c_opa);  opb = sat_ff;              end
         hcf_pkg::S_MUL_X: begin opa = signed'(x_opa);  opb = c_ff;                end
         default:          begin opa = '0;              opb = '0;                  end
      endcase
   end

   assign digit   = 2'(opb >> {~cnt_ff, 1'b0});
   assign opa_ext = {{(hcf_pkg::PROD_W - hcf_pkg::OPA_W){opa[hcf_pkg::OPA_W-1]}}, opa};

   always_comb begin
      unique case (digit)
         2'd0:    partial = '0;
         2'd1:    partial = opa_ext;
         2'd2:    partial = opa_ext << 1;
         default: partial = opa_ext + (opa_ext << 1);
      endcase
   end

   assign mul_sum    = (acc_ff << 2) + partial;
   // bits 15:8 give floor(product / 256) modulo 256, also for negatives
   assign mul_hi     = mul_sum[15:8];
   assign last_digit = (cnt_ff == hcf_pkg::CNT_W'(hcf_pkg::DIGITS - 1));

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   logic       out_free;
   logic       pix_last;
   logic [7:0] blend_pos_inc;
   logic [7:0] red_val, green_val, blue_val;

   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign pix_last      = (idx_ff == hcf_pkg::PIX_W'(hcf_pkg::PIXEL_COUNT - 1));
   assign blend_pos_inc = blend_pos_ff + 8'd1;

   // six sextants; lightness zero is black
   always_comb begin
      if (lig_ff == 8'd0) begin
         red_val = 8'd0; green_val = 8'd0; blue_val = 8'd0;
      end else begin
         unique case (sextant)
            3'd0: begin red_val = c_ff;  green_val = x_ff;  blue_val = 8'd0; end
            3'd1: begin red_val = x_ff;  green_val = c_ff;  blue_val = 8'd0; end
            3'd2: begin red_val = 8'd0;  green_val = c_ff;  blue_val = x_ff; end
            3'd3: begin red_val = 8'd0;  green_val = x_ff;  blue_val = c_ff; end
            3'd4: begin red_val = x_ff;  green_val = 8'd0;  blue_val = c_ff; end
            default: begin red_val = c_ff; green_val = 8'd0; blue_val = x_ff; end
         endcase
         red_val   = red_val + m_val;
         green_val = green_val + m_val;
         blue_val  = blue_val + m_val;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      idx_in       = idx_ff;
      blend_pos_in = blend_pos_ff;
      fade_dir_in  = fade_dir_ff;
      drift_in     = drift_ff;
      hue_in       = hue_ff;
      sat_in       = sat_ff;
      lig_in       = lig_ff;
      hcur_in      = hcur_ff;
      c_in         = c_ff;
      x_in         = x_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_idx_in   = out_idx_ff;
      out_red_in   = out_red_ff;
      out_green_in = out_green_ff;
      out_blue_in  = out_blue_ff;
      out_phase_in = out_phase_ff;
      out_last_in  = out_last_ff;

      // every multiply state retires one digit a cycle
      if (state_ff != hcf_pkg::S_IDLE && state_ff != hcf_pkg::S_EMIT) begin
         if (last_digit) begin
            cnt_in = '0;
            acc_in = '0;
         end else begin
            cnt_in = cnt_ff + hcf_pkg::CNT_W'(1);
            acc_in = mul_sum;
         end
      end

      unique case (state_ff)
         hcf_pkg::S_IDLE: begin
            cnt_in = '0;
            acc_in = '0;
            idx_in = '0;
            if (req_valid && req_render) begin
               if (single_mode) begin
                  drift_in = drift_ff + 8'd1;
                  hcur_in  = first_hue_ff + drift_ff + 8'd1;
                  sat_in   = first_sat_ff;
                  lig_in   = first_lig_ff;
                  state_in = hcf_pkg::S_MUL_C;
               end else begin
                  state_in = hcf_pkg::S_MUL_H;
               end
            end
         end
         hcf_pkg::S_MUL_H: begin
            if (last_digit) begin
               hue_in   = cur_h + mul_hi;
               state_in = hcf_pkg::S_MUL_S;
            end
         end
         hcf_pkg::S_MUL_S: begin
            if (last_digit) begin
               sat_in   = cur_s + mul_hi;
               state_in = hcf_pkg::S_MUL_L;
            end
         end
         hcf_pkg::S_MUL_L: begin
            if (last_digit) begin
               lig_in   = cur_l + mul_hi;
               state_in = hcf_pkg::S_MUL_K;
            end
         end
         hcf_pkg::S_MUL_K: begin
            if (last_digit) begin
               // first pixel sits half the chain below the center hue
               hcur_in = hue_ff - mul_sum[7:0];
               if (blend_pos_inc == hcf_pkg::FADE_END) begin
                  blend_pos_in = 8'd0;
                  fade_dir_in  = !fade_dir_ff;
               end else begin
                  blend_pos_in = blend_pos_inc;
               end
               state_in = hcf_pkg::S_MUL_C;
            end
         end
         hcf_pkg::S_MUL_C: begin
            if (last_digit) begin
               c_in     = mul_hi;
               state_in = hcf_pkg::S_MUL_X;
            end
         end
         hcf_pkg::S_MUL_X: begin
            if (last_digit) begin
               x_in     = mul_hi;
               state_in = hcf_pkg::S_EMIT;
            end
         end
         hcf_pkg::S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_idx_in   = 3'(idx_ff);
               out_red_in   = red_val;
               out_green_in = green_val;
               out_blue_in  = blue_val;
               out_phase_in = fade_dir_ff;
               out_last_in  = pix_last;
               if (pix_last) begin
                  state_in = hcf_pkg::S_IDLE;
               end else begin
                  idx_in   = idx_ff + hcf_pkg::PIX_W'(1);
                  hcur_in  = hcur_ff + hue_step_ff;
                  state_in = hcf_pkg::S_MUL_C;
               end
            end
         end
         default: state_in = hcf_pkg::S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         first_hue_ff  <= hcf_pkg::FIRST_HUE_RST;
         first_sat_ff  <= hcf_pkg::FIRST_SAT_RST;
         first_lig_ff  <= hcf_pkg::FIRST_LIG_RST;
         second_hue_ff <= hcf_pkg::SECOND_RST;
         second_sat_ff <= hcf_pkg::SECOND_RST;
         second_lig_ff <= hcf_pkg::SECOND_RST;
         hue_step_ff   <= hcf_pkg::HUE_STEP_RST;
         state_ff      <= hcf_pkg::S_IDLE;
         cnt_ff        <= '0;
         acc_ff        <= '0;
         idx_ff        <= '0;
         blend_pos_ff  <= 8'd0;
         fade_dir_ff   <= 1'b1;
         drift_ff      <= 8'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         first_hue_ff  <= first_hue_in;
         first_sat_ff  <= first_sat_in;
         first_lig_ff  <= first_lig_in;
         second_hue_ff <= second_hue_in;
         second_sat_ff <= second_sat_in;
         second_lig_ff <= second_lig_in;
         hue_step_ff   <= hue_step_in;
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         acc_ff        <= acc_in;
         idx_ff        <= idx_in;
         blend_pos_ff  <= blend_pos_in;
         fade_dir_ff   <= fade_dir_in;
         drift_ff      <= drift_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      hue_ff       <= hue_in;
      sat_ff       <= sat_in;
      lig_ff       <= lig_in;
      hcur_ff      <= hcur_in;
      c_ff         <= c_in;
      x_ff         <= x_in;
      out_idx_ff   <= out_idx_in;
      out_red_ff   <= out_red_in;
      out_green_ff <= out_green_in;
      out_blue_ff  <= out_blue_in;
      out_phase_ff <= out_phase_in;
      out_last_ff  <= out_last_in;
   end

   // ---------------------------------------------------------------------
   // Ports
   // ---------------------------------------------------------------------
   assign req_stall       = (state_ff != hcf_pkg::S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_index = out_idx_ff;
   assign rsp_red         = out_red_ff;
   assign rsp_green       = out_green_ff;
   assign rsp_blue        = out_blue_ff;
   assign rsp_fade_phase  = out_phase_ff;
   assign rsp_last        = out_last_ff;

endmodule

/* design/hcf_port_checker.sv */
// ----------------------------------------------------------------------------
// hcf_port_checker: port-level checks for the HSL color fader
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module hcf_port_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_render,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_pixel_index,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue,
   input logic       rsp_fade_phase,
   input logic       rsp_last
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_index) &&
         $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue) &&
         $stable(rsp_fade_phase) && $stable(rsp_last))
      else $error("stalled response changed");

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a render transfer keeps the request side busy while pixels are computed
   a_render_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_render |=> req_stall)
      else $error("request taken again right after a render transfer");

   // an idle transfer does not start any work
   a_idle_noop: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_render |=> !req_stall)
      else $error("idle transfer made the block busy");

   // the last flag marks the final pixel of the chain and nothing else
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last == (rsp_pixel_index == 3'(hcf_pkg::PIXEL_COUNT - 1)))
      else $error("last flag does not match the pixel index");

endmodule

bind hsl_color_fader_pixels hcf_port_checker u_hcf_port_checker (.*);

/* test/hsl_color_fader_pixels_tb.sv */
// ----------------------------------------------------------------------------
// hsl_color_fader_pixels_tb: self-checking bench for the HSL color fader
// Runs a short directed table, then phases of random render transfers under
// random register settings. A behavioral fader model predicts every pixel
// color, and each response transfer is compared against it field by field.
// ----------------------------------------------------------------------------
module hsl_color_fader_pixels_tb;

   // Index with no register behind it; writes there must be dropped
   localparam logic [2:0] REG_UNMAPPED = 3'd7;

   // Settle time long enough for a dual-mode render, with some margin
   localparam int SETTLE_CYCLES     = 80;
   localparam int HOLD_CYCLES       = 400;
   localparam int WATCHDOG_LIMIT    = 2000;
   localparam int RANDOM_PHASES     = 6;
   localparam int RENDERS_PER_PHASE = 42;
   localparam int HOLD_PHASE        = 3;
   localparam int PLAN_ROWS         = 46;

   typedef struct packed {
      logic [2:0] pixel_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       fade_phase;
      logic       last;
   } pixel_result_type;

   typedef enum logic {ROW_WRITE, ROW_RENDER} plan_kind_type;

   // One row of the directed table: a register write or a request transfer.
   // Where shade_known is set, every pixel must come out as gray 'shade'.
   typedef struct packed {
      plan_kind_type kind;
      logic [2:0]    index;
      logic [7:0]    data;
      logic          render;
      logic          shade_known;
      logic [7:0]    shade;
   } plan_row_type;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [2:0] csr_index;
   logic [7:0] csr_write_data;
   logic       req_valid;
   logic       req_stall;
   logic       req_render;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [2:0] rsp_pixel_index;
   logic [7:0] rsp_red;
   logic [7:0] rsp_green;
   logic [7:0] rsp_blue;
   logic       rsp_fade_phase;
   logic       rsp_last;

   // Model copy of the registers and of the fader state
   logic [7:0] csr_shadow [7];
   logic [7:0] blend_pos;
   logic       fade_dir;
   logic [7:0] hue_drift;

   pixel_result_type expected_pixels [$];
   int error_count = 0;
   int req_idle_pct;
   int rsp_idle_pct;
   bit hold_request;
   bit hold_done;
   bit items_in_flight;

   hsl_color_fader_pixels dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Fader model
   // ------------------------------------------------------------------------

   // Fixed-point HSL to RGB, six sextants; lightness zero is black
   function automatic logic [23:0] hsl_pixel_rgb(input int h, input int s, input int l);
      int c, hh, lo, x, m, r, g, b;
      if (l == 0) return 24'd0;
      if (l < 128) c = ((((l + 1) * 2) * s) >> 8) & 255;
      else         c = (((512 - (l + 1) * 2) * s) >> 8) & 255;
      hh = h * 6;
      lo = hh & 255;
      // rising edge of the sextant uses lo+1, falling edge 256-(lo+1)
      if ((hh & 256) == 0) x = (((lo + 1) * c) >> 8) & 255;
      else                 x = (((255 - lo) * c) >> 8) & 255;
      m = (l - (c >> 1)) & 255;
      case (hh >> 8)
         0:       begin r = c; g = x; b = 0; end
         1:       begin r = x; g = c; b = 0; end
         2:       begin r = 0; g = c; b = x; end
         3:       begin r = 0; g = x; b = c; end
         4:       begin r = x; g = 0; b = c; end
         default: begin r = c; g = 0; b = x; end
      endcase
      return {8'(r + m), 8'(g + m), 8'(b + m)};
   endfunction

   // Linear blend with floor division by 256 (>>> on a signed int floors)
   function automatic int blend_channel(input int cur, input int tgt, input int p);
      return ((((tgt - cur) * p) >>> 8) + cur) & 255;
   endfunction

   // Advance the model by one render event and queue its pixel colors
   task automatic advance_fader(input bit shade_known, input logic [7:0] shade);
      int step, k, dh, p, base_hue, sat, lig;
      int cur_h, cur_s, cur_l, tgt_h, tgt_s, tgt_l;
      bit single;
      logic [23:0] rgb;
      pixel_result_type px;
      step   = int'($signed(csr_shadow[hcf_pkg::REG_PIXEL_HUE_STEP]));
      single = csr_shadow[hcf_pkg::REG_SECOND_HUE] == 8'd0 &&
               csr_shadow[hcf_pkg::REG_SECOND_SATURATION] == 8'd0 &&
               csr_shadow[hcf_pkg::REG_SECOND_LIGHTNESS] == 8'd0;
      if (single) begin
         // fade state holds; only the drift moves
         hue_drift = hue_drift + 8'd1;
         base_hue  = (csr_shadow[hcf_pkg::REG_FIRST_HUE] + hue_drift) & 255;
         sat       = csr_shadow[hcf_pkg::REG_FIRST_SATURATION];
         lig       = csr_shadow[hcf_pkg::REG_FIRST_LIGHTNESS];
      end else begin
         if (fade_dir) begin
            cur_h = csr_shadow[hcf_pkg::REG_FIRST_HUE];
            cur_s = csr_shadow[hcf_pkg::REG_FIRST_SATURATION];
            cur_l = csr_shadow[hcf_pkg::REG_FIRST_LIGHTNESS];
            tgt_h = csr_shadow[hcf_pkg::REG_SECOND_HUE];
            tgt_s = csr_shadow[hcf_pkg::REG_SECOND_SATURATION];
            tgt_l = csr_shadow[hcf_pkg::REG_SECOND_LIGHTNESS];
         end else begin
            cur_h = csr_shadow[hcf_pkg::REG_SECOND_HUE];
            cur_s = csr_shadow[hcf_pkg::REG_SECOND_SATURATION];
            cur_l = csr_shadow[hcf_pkg::REG_SECOND_LIGHTNESS];
            tgt_h = csr_shadow[hcf_pkg::REG_FIRST_HUE];
            tgt_s = csr_shadow[hcf_pkg::REG_FIRST_SATURATION];
            tgt_l = csr_shadow[hcf_pkg::REG_FIRST_LIGHTNESS];
         end
         p = blend_pos;
         // shortest way around the wheel, centered on zero
         dh       = ((384 + tgt_h - cur_h) % 255) - 127;
         base_hue = (((dh * p) >>> 8) + cur_h) & 255;
         sat      = blend_channel(cur_s, tgt_s, p);
         lig      = blend_channel(cur_l, tgt_l, p);
         blend_pos = blend_pos + 8'd1;
         if (blend_pos == hcf_pkg::FADE_END) begin
            blend_pos = 8'd0;
            fade_dir  = ~fade_dir;
         end
      end
      for (int i = 0; i < hcf_pkg::PIXEL_COUNT; i++) begin
         // dual mode spreads hues around the center pixel
         k   = single ? i : i - hcf_pkg::PIXEL_COUNT / 2;
         rgb = hsl_pixel_rgb((base_hue + k * step) & 255, sat, lig);
         px.pixel_index = 3'(i);
         px.red         = shade_known ? shade : rgb[23:16];
         px.green       = shade_known ? shade : rgb[15:8];
         px.blue        = shade_known ? shade : rgb[7:0];
         px.fade_phase  = fade_dir;
         px.last        = (i == hcf_pkg::PIXEL_COUNT - 1);
         expected_pixels.push_back(px);
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus helpers; the tasks among them start and end at a falling edge
   // ------------------------------------------------------------------------

   function automatic plan_row_type csr_row(input logic [2:0] index, input logic [7:0] data);
      plan_row_type row;
      row       = '0;
      row.kind  = ROW_WRITE;
      row.index = index;
      row.data  = data;
      return row;
   endfunction

   function automatic plan_row_type render_row(input logic render);
      plan_row_type row;
      row        = '0;
      row.kind   = ROW_RENDER;
      row.render = render;
      return row;
   endfunction

   function automatic plan_row_type shade_row(input logic [7:0] shade);
      plan_row_type row;
      row             = render_row(1'b1);
      row.shade_known = 1'b1;
      row.shade       = shade;
      return row;
   endfunction

   // Biased toward the unsigned and signed extremes of an 8-bit field
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h7F;
         3:       return 8'h80;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 15;
         default: return 40;
      endcase
   endfunction

   // Only called while the block is idle
   task automatic write_csr(input logic [2:0] index, input logic [7:0] data);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = data;
      if (index <= hcf_pkg::REG_PIXEL_HUE_STEP) csr_shadow[index] = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // One request transfer; valid stays high afterwards so back-to-back
   // transfers follow without a gap
   task automatic send_request(input bit render, input bit shade_known,
                               input logic [7:0] shade);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid  = 1'b1;
      req_render = render;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (render) advance_fader(shade_known, shade);
      items_in_flight = 1'b1;
      @(negedge clock);
   endtask

   // Stop sending, let every expected pixel arrive, then give an idle
   // request time to retire before registers change
   task automatic drain_fader();
      req_valid = 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      items_in_flight = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      plan_row_type directed_plan [PLAN_ROWS];
      logic [7:0] sec_h, sec_s, sec_l;
      int renders;
      bit render;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_render       = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = hcf_pkg::REG_FIRST_HUE;
      csr_write_data   = 8'h00;
      req_idle_pct     = 20;
      rsp_idle_pct     = 20;

      csr_shadow[hcf_pkg::REG_FIRST_HUE]         = hcf_pkg::FIRST_HUE_RST;
      csr_shadow[hcf_pkg::REG_FIRST_SATURATION]  = hcf_pkg::FIRST_SAT_RST;
      csr_shadow[hcf_pkg::REG_FIRST_LIGHTNESS]   = hcf_pkg::FIRST_LIG_RST;
      csr_shadow[hcf_pkg::REG_SECOND_HUE]        = hcf_pkg::SECOND_RST;
      csr_shadow[hcf_pkg::REG_SECOND_SATURATION] = hcf_pkg::SECOND_RST;
      csr_shadow[hcf_pkg::REG_SECOND_LIGHTNESS]  = hcf_pkg::SECOND_RST;
      csr_shadow[hcf_pkg::REG_PIXEL_HUE_STEP]    = hcf_pkg::HUE_STEP_RST;
      blend_pos = 8'd0;
      fade_dir  = 1'b1;
      hue_drift = 8'd0;

      directed_plan = '{
         // reset values: single mode with drift, idle request in between
         render_row(1'b1),
         render_row(1'b0),
         render_row(1'b1),
         // zero saturation gives gray at the lightness
         csr_row(hcf_pkg::REG_FIRST_SATURATION, 8'h00),
         csr_row(hcf_pkg::REG_FIRST_LIGHTNESS, 8'd200),
         shade_row(8'd200),
         // lightness zero is black
         csr_row(hcf_pkg::REG_FIRST_LIGHTNESS, 8'h00),
         shade_row(8'h00),
         // full lightness collapses chroma to zero: white
         csr_row(hcf_pkg::REG_FIRST_SATURATION, 8'hFF),
         csr_row(hcf_pkg::REG_FIRST_LIGHTNESS, 8'hFF),
         shade_row(8'hFF),
         // upper lightness branch, largest positive then negative hue step
         csr_row(hcf_pkg::REG_FIRST_LIGHTNESS, 8'h80),
         csr_row(hcf_pkg::REG_PIXEL_HUE_STEP, 8'h7F),
         render_row(1'b1),
         csr_row(hcf_pkg::REG_FIRST_HUE, 8'hFF),
         csr_row(hcf_pkg::REG_PIXEL_HUE_STEP, 8'h80),
         render_row(1'b1),
         render_row(1'b0),
         // dual mode with both lightness values zero stays black
         csr_row(hcf_pkg::REG_FIRST_LIGHTNESS, 8'h00),
         csr_row(hcf_pkg::REG_SECOND_HUE, 8'h01),
         shade_row(8'h00),
         // dual mode, no saturation on either side, equal lightness
         csr_row(hcf_pkg::REG_FIRST_SATURATION, 8'h00),
         csr_row(hcf_pkg::REG_FIRST_LIGHTNESS, 8'd100),
         csr_row(hcf_pkg::REG_SECOND_HUE, 8'hC8),
         csr_row(hcf_pkg::REG_SECOND_LIGHTNESS, 8'd100),
         shade_row(8'd100),
         shade_row(8'd100),
         // hue crossing zero the short way
         csr_row(hcf_pkg::REG_FIRST_HUE, 8'hFA),
         csr_row(hcf_pkg::REG_FIRST_SATURATION, 8'hFF),
         csr_row(hcf_pkg::REG_FIRST_LIGHTNESS, 8'h7F),
         csr_row(hcf_pkg::REG_SECOND_HUE, 8'h05),
         csr_row(hcf_pkg::REG_SECOND_SATURATION, 8'h80),
         csr_row(hcf_pkg::REG_SECOND_LIGHTNESS, 8'hFF),
         csr_row(hcf_pkg::REG_PIXEL_HUE_STEP, 8'h10),
         render_row(1'b1),
         render_row(1'b1),
         render_row(1'b1),
         render_row(1'b1),
         // write to an unmapped index must not disturb anything
         csr_row(REG_UNMAPPED, 8'h55),
         render_row(1'b1),
         render_row(1'b0),
         // back to single mode; fade state must have held meanwhile
         csr_row(hcf_pkg::REG_SECOND_HUE, 8'h00),
         csr_row(hcf_pkg::REG_SECOND_SATURATION, 8'h00),
         csr_row(hcf_pkg::REG_SECOND_LIGHTNESS, 8'h00),
         render_row(1'b1),
         render_row(1'b1)
      };

      // synchronous reset
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int n = 0; n < PLAN_ROWS; n++) begin
         if (directed_plan[n].kind == ROW_WRITE) begin
            if (items_in_flight) drain_fader();
            write_csr(directed_plan[n].index, directed_plan[n].data);
         end else begin
            send_request(directed_plan[n].render, directed_plan[n].shade_known,
                         directed_plan[n].shade);
         end
      end

      // Random phases, all in dual mode; single mode is covered by the
      // table. Together with the dual renders of the table they carry the
      // fade position past its wrap, so the direction flips at least once.
      // The last phase runs with no idling on either side.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_fader();
         if (phase == RANDOM_PHASES - 1) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = pick_idle_pct();
            rsp_idle_pct = pick_idle_pct();
         end
         sec_h = pick_byte();
         sec_s = pick_byte();
         sec_l = pick_byte();
         if (sec_h == 8'h00 && sec_s == 8'h00 && sec_l == 8'h00) sec_h = 8'h40;
         write_csr(hcf_pkg::REG_FIRST_HUE, pick_byte());
         write_csr(hcf_pkg::REG_FIRST_SATURATION, pick_byte());
         write_csr(hcf_pkg::REG_FIRST_LIGHTNESS, pick_byte());
         write_csr(hcf_pkg::REG_SECOND_HUE, sec_h);
         write_csr(hcf_pkg::REG_SECOND_SATURATION, sec_s);
         write_csr(hcf_pkg::REG_SECOND_LIGHTNESS, sec_l);
         write_csr(hcf_pkg::REG_PIXEL_HUE_STEP, pick_byte());
         write_csr(REG_UNMAPPED, 8'($urandom_range(0, 255)));

         // long receiver hold-off with the sender pushing into it, so the
         // output buffer fills and the request side stalls
         if (phase == HOLD_PHASE) begin
            req_idle_pct = 0;
            hold_request = 1'b1;
         end

         renders = 0;
         while (renders < RENDERS_PER_PHASE) begin
            render = $urandom_range(0, 99) < 98;
            send_request(render, 1'b0, 8'h00);
            if (render) renders++;
         end
      end

      drain_fader();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Receiver: random stall bursts, plus the one long hold-off on request
   // ------------------------------------------------------------------------
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall = 1'b0;
            hold_done = 1'b1;
         end else if ($urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response checking against the oldest expected pixel
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_pixels.size() == 0) begin
            $error("pixel transfer with none expected: pixel_index %0d", rsp_pixel_index);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("pixel_index", want.pixel_index, rsp_pixel_index);
            check_field("red", want.red, rsp_red);
            check_field("green", want.green, rsp_green);
            check_field("blue", want.blue, rsp_blue);
            check_field("fade_phase", want.fade_phase, rsp_fade_phase);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: too long without any transfer on either channel
   // ------------------------------------------------------------------------
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
